>>> rtl/cmac_aes128_tag_unit_defines.svh
// Assertion macros shared by the CMAC tag unit RTL.
`ifndef CMAC_AES128_TAG_UNIT_DEFINES_SVH
`define CMAC_AES128_TAG_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CMAC_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// Implication checked in the cycle after the condition.
`define CMAC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

>>> rtl/cmac_pkg.sv
// Types, constants and AES helper functions for the CMAC tag unit.
package cmac_pkg;
   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic [4:0]  byte_count;
      logic        last_block;
      logic [63:0] expected_high;
      logic [63:0] expected_low;
      logic [4:0]  compare_length;
   } cmac_req_type;

   typedef struct packed {
      logic [63:0] tag_high;
      logic [63:0] tag_low;
      logic        tag_match;
   } cmac_rsp_type;

   // Item as prepared by the front end: data block already masked and padded.
   typedef struct packed {
      logic [127:0] data;
      logic         last;
      logic         full;
      logic [127:0] expected;
      logic [15:0]  cmp_mask;
   } cmac_job_type;

   typedef enum logic [1:0] {
      ENG_IDLE  = 2'd0,
      ENG_SUBKEY = 2'd1,
      ENG_BLOCK = 2'd2,
      ENG_OUT   = 2'd3
   } cmac_eng_state_type;

   localparam logic       CSR_KEY_HIGH = 1'b0;
   localparam logic       CSR_KEY_LOW  = 1'b1;
   localparam logic [7:0] RB_CONST     = 8'h87;
   localparam logic [7:0] PAD_BYTE     = 8'h80;
   localparam logic [4:0] BLOCK_BYTES  = 5'd16;
   localparam int         NUM_ROUNDS   = 10;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a 128-bit block, byte 0 in the top bits.
   function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
      byte_at = s[127-8*i -: 8];
   endfunction

   // One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
   function automatic logic [127:0] aes_round(input logic [127:0] s,
                                              input logic [127:0] rk,
                                              input logic         final_rnd);
      logic [7:0]   t [16];
      logic [127:0] o;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            t[j+4*c] = SBOX[byte_at(s, j + 4*((c + j) % 4))];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
         if (final_rnd) begin
            o[127-32*c -: 32] = {a0, a1, a2, a3};
         end else begin
            o[127-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                 a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                 a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                 xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
         end
      end
      aes_round = o ^ rk;
   endfunction

   // Next round key from the current one and the round constant.
   function automatic logic [127:0] key_step(input logic [127:0] k,
                                             input logic [7:0]   rcon);
      logic [31:0] w0, w1, w2, w3, g;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      g  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ g;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      key_step = {w0, w1, w2, w3};
   endfunction

   // Doubling in GF(2^128) with the CMAC feedback constant.
   function automatic logic [127:0] gf_double(input logic [127:0] v);
      gf_double = {v[126:0], 1'b0} ^ {120'd0, (v[127] ? RB_CONST : 8'h00)};
   endfunction
endpackage

>>> rtl/cmac_front.sv
// Front end: accepts request items, masks and pads the block, builds the compare mask.
module cmac_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cmac_pkg::cmac_req_type req_data,
   output logic                  job_valid,
   input  logic                  job_ready,
   output cmac_pkg::cmac_job_type job_data
);
   import cmac_pkg::*;

   localparam int DEPTH = 2;

   cmac_job_type q_ff [DEPTH];
   logic         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   cmac_job_type job;
   logic [4:0]   n, m;
   logic         push, pop;

   always_comb begin
      n = (req_data.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : req_data.byte_count;
      m = (req_data.compare_length > BLOCK_BYTES) ? BLOCK_BYTES : req_data.compare_length;
      job.last     = req_data.last_block;
      job.full     = (n == BLOCK_BYTES);
      job.expected = {req_data.expected_high, req_data.expected_low};
      for (int i = 0; i < 16; i++) begin
         job.cmp_mask[15-i] = (5'(i) < m);
         if (!req_data.last_block || 5'(i) < n) begin
            job.data[127-8*i -: 8] = byte_at({req_data.block_high, req_data.block_low}, i);
         end else if (5'(i) == n) begin
            job.data[127-8*i -: 8] = PAD_BYTE;
         end else begin
            job.data[127-8*i -: 8] = 8'h00;
         end
      end
   end

   assign req_stall = (count_ff == 2'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != 2'd0);
   assign pop       = job_valid && job_ready;
   assign job_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= job;
      end
   end

   `include "cmac_aes128_tag_unit_defines.svh"
   `CMAC_ASSERT_IMP(a_no_overflow, clock, reset, 1'b1, count_ff <= 2'(DEPTH))
   `CMAC_ASSERT_NEXT(a_push_counts, clock, reset, push && !pop, count_ff == $past(count_ff) + 2'd1)
   `CMAC_ASSERT_NEXT(a_pop_counts, clock, reset, pop && !push, count_ff == $past(count_ff) - 2'd1)
endmodule

>>> rtl/cmac_engine.sv
// Back end: subkey derivation, CBC chaining over a round-per-cycle AES core, tag output.
module cmac_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [127:0]          key,
   input  logic                  key_written,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  cmac_pkg::cmac_job_type job_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cmac_pkg::cmac_rsp_type rsp_data
);
   import cmac_pkg::*;

   cmac_eng_state_type state_ff, state_in;
   cmac_job_type       job_ff, job_in;
   logic [127:0]       st_ff, st_in, rk_ff, rk_in, chain_ff, chain_in, k1_ff, k1_in;
   logic [7:0]         rcon_ff, rcon_in;
   logic [3:0]         rnd_ff, rnd_in;
   logic               sk_ready_ff, sk_ready_in;
   logic               out_valid_ff, out_valid_in;
   cmac_rsp_type       out_ff, out_in;
   logic [127:0]       round_out, next_rk, tag;
   logic               out_free, take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign job_ready = (state_ff == ENG_IDLE) && out_free;
   assign take      = job_valid && job_ready;
   assign next_rk   = key_step(rk_ff, rcon_ff);
   assign round_out = aes_round(st_ff, next_rk, rnd_ff == 4'(NUM_ROUNDS));
   assign tag       = round_out;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (take) begin
               state_in = sk_ready_ff ? ENG_BLOCK : ENG_SUBKEY;
            end
         end
         ENG_SUBKEY: begin
            if (rnd_ff == 4'(NUM_ROUNDS)) begin
               state_in = ENG_BLOCK;
            end
         end
         ENG_BLOCK: begin
            if (rnd_ff == 4'(NUM_ROUNDS)) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   always_comb begin
      job_in       = job_ff;
      st_in        = st_ff;
      rk_in        = rk_ff;
      rcon_in      = rcon_ff;
      rnd_in       = rnd_ff;
      chain_in     = chain_ff;
      k1_in        = k1_ff;
      sk_ready_in  = sk_ready_ff && !key_written;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (take) begin
               job_in  = job_data;
               rk_in   = key;
               rcon_in = 8'h01;
               rnd_in  = 4'd1;
               st_in   = key;
            end
         end
         ENG_SUBKEY: begin
            st_in   = round_out;
            rk_in   = next_rk;
            rcon_in = xtime(rcon_ff);
            rnd_in  = rnd_ff + 4'd1;
            if (rnd_ff == 4'(NUM_ROUNDS)) begin
               k1_in       = gf_double(round_out);
               sk_ready_in = 1'b1;
               rk_in       = key;
               rcon_in     = 8'h01;
               rnd_in      = 4'd1;
               st_in       = key;
            end
         end
         ENG_BLOCK: begin
            st_in   = round_out;
            rk_in   = next_rk;
            rcon_in = xtime(rcon_ff);
            rnd_in  = rnd_ff + 4'd1;
            if (rnd_ff == 4'(NUM_ROUNDS)) begin
               if (job_ff.last) begin
                  chain_in     = 128'd0;
                  out_valid_in = 1'b1;
                  out_in.tag_high = tag[127:64];
                  out_in.tag_low  = tag[63:0];
                  out_in.tag_match = ((tag ^ job_ff.expected) &
                     {{8{job_ff.cmp_mask[15]}}, {8{job_ff.cmp_mask[14]}},
                      {8{job_ff.cmp_mask[13]}}, {8{job_ff.cmp_mask[12]}},
                      {8{job_ff.cmp_mask[11]}}, {8{job_ff.cmp_mask[10]}},
                      {8{job_ff.cmp_mask[9]}},  {8{job_ff.cmp_mask[8]}},
                      {8{job_ff.cmp_mask[7]}},  {8{job_ff.cmp_mask[6]}},
                      {8{job_ff.cmp_mask[5]}},  {8{job_ff.cmp_mask[4]}},
                      {8{job_ff.cmp_mask[3]}},  {8{job_ff.cmp_mask[2]}},
                      {8{job_ff.cmp_mask[1]}},  {8{job_ff.cmp_mask[0]}}}) == 128'd0;
               end else begin
                  chain_in = round_out;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         sk_ready_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         chain_ff     <= 128'd0;
      end else begin
         state_ff     <= state_in;
         sk_ready_ff  <= sk_ready_in;
         out_valid_ff <= out_valid_in;
         chain_ff     <= chain_in;
      end
   end

   function automatic logic [127:0] block_in_sk(input logic [127:0] enc0);
      logic [127:0] k1;
      k1 = gf_double(enc0);
      block_in_sk = chain_ff ^ job_ff.data ^
                    (job_ff.last ? (job_ff.full ? k1 : gf_double(k1)) : 128'd0);
   endfunction

   // Whitening: block pass loads key^chain^data (^K1/K2 if last); subkey pass loads key.
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      rk_ff   <= rk_in;
      rcon_ff <= rcon_in;
      rnd_ff  <= rnd_in;
      k1_ff   <= k1_in;
      out_ff  <= out_in;
      if (state_ff == ENG_IDLE && take && sk_ready_ff) begin
         st_ff <= key ^ chain_ff ^ job_data.data ^
                  (job_data.last ? (job_data.full ? k1_ff : gf_double(k1_ff)) : 128'd0);
      end else if (state_ff == ENG_SUBKEY && rnd_ff == 4'(NUM_ROUNDS)) begin
         st_ff <= key ^ block_in_sk(round_out);
      end else begin
         st_ff <= st_in;
      end
   end

   `include "cmac_aes128_tag_unit_defines.svh"
   `CMAC_ASSERT_IMP(a_take_idle, clock, reset, take, state_ff == ENG_IDLE)
   `CMAC_ASSERT_NEXT(a_out_hold, clock, reset, out_valid_ff && rsp_stall, out_valid_ff)
   `CMAC_ASSERT_IMP(a_round_range, clock, reset, state_ff != ENG_IDLE,
                    rnd_ff >= 4'd1 && rnd_ff <= 4'(NUM_ROUNDS))
endmodule

>>> rtl/cmac_aes128_tag_unit.sv
// Top level of the AES-128 CMAC tag unit.
// The block computes an AES-128 CMAC over a message fed as 16-byte items on
// the req_ channel; byte 0 of a block is the top byte of block_high.
// Every item is accepted when req_valid is high and req_stall is low.
// Only the item flagged last_block yields one result on the rsp_ channel:
// the tag and a match flag over the first compare_length bytes.
// The key is written through the csr_ port, index 0 for the high half and
// index 1 for the low half, by the user only while the block is idle;
// the block itself does not enforce this. The AES core runs one round per
// cycle, and its result feeds the next block through the CBC chain.
// The first block after reset or a key write first encrypts zero to
// derive subkey K1.
// A two-entry queue sits between the front end and the AES engine, so new
// items are accepted while a block is in progress.
// A tag appears on rsp_ in the cycle after its last round and is held in an
// output register while rsp_stall is high; the engine then waits to start
// the next item but the queue keeps accepting until full.
// Reset is synchronous and active high; it clears the chain, the subkey
// flag, the queue and the output, and sets the key to zero.
module cmac_aes128_tag_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cmac_pkg::cmac_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cmac_pkg::cmac_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [63:0]            csr_wdata
);
   import cmac_pkg::*;

   logic [63:0]  key_high_ff, key_high_in, key_low_ff, key_low_in;
   logic         csr_write;
   logic         job_valid, job_ready;
   cmac_job_type job_data;

   // Key registers accept a write on every cycle.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_in = csr_wdata;
            CSR_KEY_LOW:  key_low_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= 64'd0;
         key_low_ff  <= 64'd0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   cmac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data)
   );

   cmac_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .key         ({key_high_ff, key_low_ff}),
      .key_written (csr_write),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job_data    (job_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   `include "cmac_aes128_tag_unit_defines.svh"
   `CMAC_ASSERT_NEXT(a_key_write, clock, reset, csr_write && csr_index == CSR_KEY_HIGH,
                     key_high_ff == $past(csr_wdata))
   `CMAC_ASSERT_NEXT(a_key_keep, clock, reset, !csr_write,
                     key_low_ff == $past(key_low_ff))
   `CMAC_ASSERT_IMP(a_rsp_hold, clock, reset, $past(rsp_valid && rsp_stall) && !$past(reset),
                    rsp_valid)
endmodule
